### design/five_point_neg_laplacian_stencil_defines.svh
// Assertion macros shared by the stencil top level.
`ifndef FIVE_POINT_NEG_LAPLACIAN_STENCIL_DEFINES_SVH
`define FIVE_POINT_NEG_LAPLACIAN_STENCIL_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define NLAP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stencil assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define NLAP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stencil assertion failed");

`endif

### design/nlap_pkg.sv
// Types, codes and constants shared by the stencil modules.
package nlap_pkg;

    localparam int DEF_MAX_ROWS = 256;
    localparam int DEF_MAX_COLS = 4096;

    localparam int VAL_W  = 32;
    localparam int ROWS_W = 9;
    localparam int COLS_W = 13;
    localparam int ROWI_W = 8;
    localparam int COLI_W = 12;

    localparam logic [31:0] X_WEIGHT_RST    = 32'd65536;
    localparam logic [31:0] Y_WEIGHT_RST    = 32'd65536;
    localparam logic [8:0]  ROWS_IN_USE_RST = 9'd256;
    localparam logic [12:0] COLS_IN_USE_RST = 13'd4096;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_FLUSH  = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        CFG_X_WEIGHT    = 2'd0,
        CFG_Y_WEIGHT    = 2'd1,
        CFG_ROWS_IN_USE = 2'd2,
        CFG_COLS_IN_USE = 2'd3
    } cfg_idx_t;

    // One cell ready for the arithmetic: its five values and which sides exist.
    typedef struct packed {
        logic signed [VAL_W-1:0] prev;
        logic signed [VAL_W-1:0] cur;
        logic signed [VAL_W-1:0] nxt;
        logic signed [VAL_W-1:0] south;
        logic signed [VAL_W-1:0] north;
        logic                    has_prev;
        logic                    has_next;
        logic                    has_south;
        logic                    has_north;
        logic [ROWI_W-1:0]       row;
        logic [COLI_W-1:0]       col;
        logic                    last;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

### design/nlap_if.sv
// Valid/ready channel interfaces for stencil input items and result items.
interface nlap_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] sample;

    modport source (output valid, req_type, sample, input ready);
    modport sink   (input valid, req_type, sample, output ready);
endinterface

interface nlap_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result;
    logic [7:0]  row_index;
    logic [11:0] col_index;
    logic        overflow;
    logic        frame_end;

    modport source (output valid, result, row_index, col_index, overflow, frame_end,
                    input ready);
    modport sink   (input valid, result, row_index, col_index, overflow, frame_end,
                    output ready);
endinterface

### design/nlap_queue.sv
// Short queue of classified cells between the front and back parts.
module nlap_queue
    import nlap_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  op_t    wdata,
    input  logic   pop,
    output op_t    rdata,
    output qstat_t status
);

    op_t               buf_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign status.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign status.empty = (cnt_reg == '0);
    assign rdata        = buf_reg[rd_ptr_reg];

    // Store a pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

### design/nlap_front.sv
// Front part: accepts items, tracks the raster position, keeps the column buffers.
module nlap_front
    import nlap_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  logic              clk,
    input  logic              rst_n,
    nlap_in_if.sink           in_ch,
    input  logic [ROWS_W-1:0] rows_in_use,
    input  logic [COLS_W-1:0] cols_in_use,
    input  logic              q_full,
    output logic              push,
    output op_t               op
);

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    // Position and phase
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic             drain_reg;
    logic             sel_reg;

    // Column buffers: bank 0 and bank 1, roles swapped by sel_reg
    logic [VAL_W-1:0] mem0 [MAX_ROWS];
    logic [VAL_W-1:0] mem1 [MAX_ROWS];
    logic [VAL_W-1:0] rd0_reg;
    logic [VAL_W-1:0] rd1_reg;

    // Clearing pass over both banks after reset
    logic             clr_reg;
    logic [ROW_W-1:0] clr_addr_reg;

    // Sliding window over the newer column and the staged cell
    logic [VAL_W-1:0]  row0_reg;
    logic [VAL_W-1:0]  cur_reg;
    logic [VAL_W-1:0]  prev_reg;
    logic [VAL_W-1:0]  north_reg;
    logic              s1_v_reg;
    logic              s1_sel_reg;
    logic              has_prev_reg;
    logic              has_next_reg;
    logic              has_south_reg;
    logic              has_north_reg;
    logic [ROWI_W-1:0] row_out_reg;
    logic [COLI_W-1:0] col_out_reg;
    logic              last_reg;

    logic [ROW_W:0]   nx;
    logic [COL_W:0]   ny;
    logic             acc;
    logic             take_sample;
    logic             take_flush;
    logic             eff;
    logic             row_last;
    logic             col_last;
    logic [ROW_W-1:0] next_addr;
    logic [ROW_W-1:0] addr0;
    logic [ROW_W-1:0] addr1;
    logic [ROW_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic             wr0;
    logic             wr1;
    logic [VAL_W-1:0] d0;
    logic [VAL_W-1:0] d1;
    logic [VAL_W-1:0] nxt_data;
    logic [VAL_W-1:0] south_data;

    // Clamp the extents to 1..MAX
    always_comb
    begin
        if (rows_in_use == '0)
        begin
            nx = (ROW_W + 1)'(1);
        end
        else if (32'(rows_in_use) > MAX_ROWS)
        begin
            nx = (ROW_W + 1)'(MAX_ROWS);
        end
        else
        begin
            nx = (ROW_W + 1)'(rows_in_use);
        end

        if (cols_in_use == '0)
        begin
            ny = (COL_W + 1)'(1);
        end
        else if (32'(cols_in_use) > MAX_COLS)
        begin
            ny = (COL_W + 1)'(MAX_COLS);
        end
        else
        begin
            ny = (COL_W + 1)'(cols_in_use);
        end
    end

    // Classify the transfer; off-phase items are dropped
    assign in_ch.ready = !clr_reg && (!s1_v_reg || !q_full);
    assign acc         = in_ch.valid && in_ch.ready;
    assign take_sample = acc && !drain_reg && (req_t'(in_ch.req_type) == REQ_SAMPLE);
    assign take_flush  = acc && drain_reg && (req_t'(in_ch.req_type) == REQ_FLUSH);
    assign eff         = take_sample || take_flush;

    assign row_last  = ((ROW_W + 1)'(row_reg) + 1'b1) >= nx;
    assign col_last  = ((COL_W + 1)'(col_reg) + 1'b1) >= ny;
    assign next_addr = row_reg + 1'b1;

    // Older bank reads the current row, newer bank reads one row ahead
    assign addr0 = sel_reg ? next_addr : row_reg;
    assign addr1 = sel_reg ? row_reg : next_addr;

    // Write zeros during the clearing pass, else the sample into the older bank
    assign wr_addr = clr_reg ? clr_addr_reg : row_reg;
    assign wr_data = clr_reg ? '0 : in_ch.sample;
    assign wr0     = clr_reg || (take_sample && !sel_reg);
    assign wr1     = clr_reg || (take_sample && sel_reg);

    // Read before write on the older bank
    always_ff @(posedge clk)
    begin
        if (eff)
        begin
            rd0_reg <= mem0[addr0];
            rd1_reg <= mem1[addr1];
        end
        if (wr0)
        begin
            mem0[wr_addr] <= wr_data;
        end
        if (wr1)
        begin
            mem1[wr_addr] <= wr_data;
        end
    end

    // Step the clearing pass, one row of both banks per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_reg)
        begin
            if (clr_addr_reg == ROW_W'(MAX_ROWS - 1))
            begin
                clr_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    assign d0         = rd0_reg;
    assign d1         = rd1_reg;
    assign nxt_data   = s1_sel_reg ? d0 : d1;
    assign south_data = s1_sel_reg ? d1 : d0;

    // Shift the window and stage the cell operands
    always_ff @(posedge clk)
    begin
        if (eff)
        begin
            cur_reg       <= (row_reg == '0) ? row0_reg : nxt_data;
            prev_reg      <= cur_reg;
            north_reg     <= in_ch.sample;
            has_prev_reg  <= (row_reg != '0);
            has_next_reg  <= !row_last;
            has_south_reg <= take_sample ? (col_reg > COL_W'(1)) : (col_reg != '0);
            has_north_reg <= take_sample;
            row_out_reg   <= ROWI_W'(row_reg);
            col_out_reg   <= take_sample ? COLI_W'(col_reg - 1'b1) : COLI_W'(col_reg);
            last_reg      <= take_flush && row_last;
        end
        if (take_sample && (row_reg == '0))
        begin
            row0_reg <= in_ch.sample;
        end
    end

    // Advance position, phase and bank roles
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg    <= '0;
            col_reg    <= '0;
            drain_reg  <= 1'b0;
            sel_reg    <= 1'b0;
            s1_v_reg   <= 1'b0;
            s1_sel_reg <= 1'b0;
        end
        else
        begin
            if (eff)
            begin
                s1_v_reg   <= take_flush || (col_reg != '0);
                s1_sel_reg <= sel_reg;
            end
            else if (push || acc)
            begin
                s1_v_reg <= 1'b0;
            end

            if (take_sample)
            begin
                if (row_last)
                begin
                    row_reg <= '0;
                    sel_reg <= ~sel_reg;
                    if (col_last)
                    begin
                        drain_reg <= 1'b1;
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
                else
                begin
                    row_reg <= row_reg + 1'b1;
                end
            end
            else if (take_flush)
            begin
                if (row_last)
                begin
                    row_reg   <= '0;
                    col_reg   <= '0;
                    drain_reg <= 1'b0;
                end
                else
                begin
                    row_reg <= row_reg + 1'b1;
                end
            end
        end
    end

    // Hand the staged cell to the queue
    assign push         = s1_v_reg && !q_full;
    assign op.prev      = prev_reg;
    assign op.cur       = cur_reg;
    assign op.nxt       = nxt_data;
    assign op.south     = south_data;
    assign op.north     = north_reg;
    assign op.has_prev  = has_prev_reg;
    assign op.has_next  = has_next_reg;
    assign op.has_south = has_south_reg;
    assign op.has_north = has_north_reg;
    assign op.row       = row_out_reg;
    assign op.col       = col_out_reg;
    assign op.last      = last_reg;

endmodule

### design/nlap_back.sv
// Back part: products, weighted sums, rounding and saturation, result register.
module nlap_back
    import nlap_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [VAL_W-1:0] x_weight,
    input  logic [VAL_W-1:0] y_weight,
    input  qstat_t           q_status,
    input  op_t              q_op,
    output logic             pop,
    nlap_out_if.source       out_ch
);

    localparam int PW = 2 * VAL_W + 1;
    localparam int SW = PW + 3;
    localparam int RW = SW - 16;

    localparam logic signed [SW-1:0] HALF    = SW'(32768);
    localparam logic signed [RW-1:0] SAT_MAX = RW'(64'sh7FFF_FFFF);
    localparam logic signed [RW-1:0] SAT_MIN = -RW'(64'sh8000_0000);

    logic en;

    // Product stage
    logic                    a_v_reg;
    logic signed [PW-1:0]    a_pxp_reg, a_pxn_reg, a_pxv_reg;
    logic signed [PW-1:0]    a_pys_reg, a_pyn_reg, a_pyv_reg;
    logic                    a_hp_reg, a_hn_reg, a_hs_reg, a_hu_reg;
    logic [ROWI_W-1:0]       a_row_reg;
    logic [COLI_W-1:0]       a_col_reg;
    logic                    a_last_reg;

    // Sum stage
    logic                    b_v_reg;
    logic signed [SW-1:0]    b_x_reg, b_y_reg;
    logic [ROWI_W-1:0]       b_row_reg;
    logic [COLI_W-1:0]       b_col_reg;
    logic                    b_last_reg;

    // Result register
    logic                    out_v_reg;
    logic [VAL_W-1:0]        res_reg;
    logic [ROWI_W-1:0]       row_reg;
    logic [COLI_W-1:0]       col_reg;
    logic                    ovf_reg;
    logic                    end_reg;

    logic signed [VAL_W:0]   xs, ys;
    logic signed [SW-1:0]    exp_, exn, exv, eys, eyn, eyv;
    logic signed [SW-1:0]    xsum, ysum, total;
    logic signed [RW-1:0]    rnd;
    logic [VAL_W-1:0]        sat;
    logic                    sat_hit;

    assign en  = !out_v_reg || out_ch.ready;
    assign pop = en && !q_status.empty;
    assign xs  = $signed({1'b0, x_weight});
    assign ys  = $signed({1'b0, y_weight});

    // Multiply each neighbor and the center by its weight
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_pxp_reg  <= xs * $signed(q_op.prev);
            a_pxn_reg  <= xs * $signed(q_op.nxt);
            a_pxv_reg  <= xs * $signed(q_op.cur);
            a_pys_reg  <= ys * $signed(q_op.south);
            a_pyn_reg  <= ys * $signed(q_op.north);
            a_pyv_reg  <= ys * $signed(q_op.cur);
            a_hp_reg   <= q_op.has_prev;
            a_hn_reg   <= q_op.has_next;
            a_hs_reg   <= q_op.has_south;
            a_hu_reg   <= q_op.has_north;
            a_row_reg  <= q_op.row;
            a_col_reg  <= q_op.col;
            a_last_reg <= q_op.last;
        end
    end

    // Combine per axis; a missing x side counts the center twice
    always_comb
    begin
        exp_ = SW'(a_pxp_reg);
        exn  = SW'(a_pxn_reg);
        exv  = SW'(a_pxv_reg);
        eys  = SW'(a_pys_reg);
        eyn  = SW'(a_pyn_reg);
        eyv  = SW'(a_pyv_reg);
        xsum = (a_hp_reg ? (exv - exp_) : (exv <<< 1))
             + (a_hn_reg ? (exv - exn) : (exv <<< 1));
        ysum = (a_hs_reg ? (eyv - eys) : '0)
             + (a_hu_reg ? (eyv - eyn) : '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_x_reg    <= xsum;
            b_y_reg    <= ysum;
            b_row_reg  <= a_row_reg;
            b_col_reg  <= a_col_reg;
            b_last_reg <= a_last_reg;
        end
    end

    // Round half up to Q16.16, then saturate
    always_comb
    begin
        total = b_x_reg + b_y_reg + HALF;
        rnd   = total[SW-1:16];
        if (rnd > SAT_MAX)
        begin
            sat     = 32'h7FFF_FFFF;
            sat_hit = 1'b1;
        end
        else if (rnd < SAT_MIN)
        begin
            sat     = 32'h8000_0000;
            sat_hit = 1'b1;
        end
        else
        begin
            sat     = rnd[VAL_W-1:0];
            sat_hit = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= sat;
            ovf_reg <= sat_hit;
            row_reg <= b_row_reg;
            col_reg <= b_col_reg;
            end_reg <= b_last_reg;
        end
    end

    // Advance stage valids together while the result slot is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg   <= 1'b0;
            b_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg   <= pop;
            b_v_reg   <= a_v_reg;
            out_v_reg <= b_v_reg;
        end
    end

    assign out_ch.valid     = out_v_reg;
    assign out_ch.result    = res_reg;
    assign out_ch.row_index = row_reg;
    assign out_ch.col_index = col_reg;
    assign out_ch.overflow  = ovf_reg;
    assign out_ch.frame_end = end_reg;

endmodule

### design/five_point_neg_laplacian_stencil.sv
// Top level of the streaming negative five-point Laplacian stencil.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+---------------------------------------------
//  in_ch   | in  | valid/ready       | req_type, sample
//  out_ch  | out | valid/ready       | result, row_index, col_index, overflow,
//          |     |                   | frame_end
//  cfg     | in  | cfg_we            | cfg_index, cfg_data
//
// One item is taken per cycle unless the clearing pass runs or a staged cell waits on
// a full queue; the cell that an item completes then passes the accept stage, queue,
// product stage, sum stage and result register. The rate is set by the column
// buffer banks: one read per bank per item. Reset starts a clearing pass over all
// MAX_ROWS rows of both banks; input waits for it. A stalled result holds the back
// part; the queue lets input transfers continue until it fills.
`include "five_point_neg_laplacian_stencil_defines.svh"

module five_point_neg_laplacian_stencil
    import nlap_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  logic        clk,
    input  logic        rst_n,
    nlap_in_if.sink     in_ch,
    nlap_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [VAL_W-1:0]  x_weight_reg;
    logic [VAL_W-1:0]  y_weight_reg;
    logic [ROWS_W-1:0] rows_in_use_reg;
    logic [COLS_W-1:0] cols_in_use_reg;

    logic   q_push;
    logic   q_pop;
    op_t    q_wdata;
    op_t    q_rdata;
    qstat_t q_status;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_weight_reg    <= X_WEIGHT_RST;
            y_weight_reg    <= Y_WEIGHT_RST;
            rows_in_use_reg <= ROWS_IN_USE_RST;
            cols_in_use_reg <= COLS_IN_USE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_X_WEIGHT:    x_weight_reg    <= cfg_data;
                CFG_Y_WEIGHT:    y_weight_reg    <= cfg_data;
                CFG_ROWS_IN_USE: rows_in_use_reg <= cfg_data[ROWS_W-1:0];
                CFG_COLS_IN_USE: cols_in_use_reg <= cfg_data[COLS_W-1:0];
                default:         x_weight_reg    <= x_weight_reg;
            endcase
        end
    end

    nlap_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .rows_in_use (rows_in_use_reg),
        .cols_in_use (cols_in_use_reg),
        .q_full      (q_status.full),
        .push        (q_push),
        .op          (q_wdata)
    );

    nlap_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .status (q_status)
    );

    nlap_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .x_weight (x_weight_reg),
        .y_weight (y_weight_reg),
        .q_status (q_status),
        .q_op     (q_rdata),
        .pop      (q_pop),
        .out_ch   (out_ch)
    );

    // Queue never takes a push while full nor pops while empty
    `NLAP_ASSERT_IMP(a_q_no_overrun, q_push, !q_status.full)
    `NLAP_ASSERT_IMP(a_q_no_underrun, q_pop, !q_status.empty)
    // A stalled result stays valid
    `NLAP_ASSERT_NXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid)
    // A saturated result sits at one of the two limits
    `NLAP_ASSERT_IMP(a_sat_limit, out_ch.valid && out_ch.overflow,
        (out_ch.result == 32'h7FFF_FFFF) || (out_ch.result == 32'h8000_0000))

endmodule
